### hdl/record_merge_sorter_defines.svh
// Assertion macros shared by the record merge sorter RTL.
// Included by the top level; no other dependencies.
`ifndef RECORD_MERGE_SORTER_DEFINES_SVH
`define RECORD_MERGE_SORTER_DEFINES_SVH

// The condition implies the consequence in the same cycle.
`define RMS_ASSERT_SAME(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("record_merge_sorter assertion failed");

// The condition implies the consequence in the next cycle.
`define RMS_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("record_merge_sorter assertion failed");

`endif

### hdl/rms_pkg.sv
// Shared types, constants and key selection for the record merge sorter.
// No dependencies.
`timescale 1ns / 1ps
package rms_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int POS_W     = 6;
  localparam int KEY_W     = 16;

  localparam logic [2:0] KEY_SPACE   = 3'd0;
  localparam logic [2:0] KEY_CHANNEL = 3'd1;
  localparam logic [2:0] KEY_REMOTE  = 3'd2;
  localparam logic [2:0] KEY_NETWORK = 3'd3;
  localparam logic [2:0] KEY_STREAM  = 3'd4;
  localparam logic [2:0] KEY_SERVICE = 3'd5;

  localparam logic [1:0] REG_SORT_KEY   = 2'd0;
  localparam logic [1:0] REG_DESCENDING = 2'd1;

  typedef struct packed {
    logic [6:0]  space;
    logic [15:0] channel;
    logic [7:0]  remote_key;
    logic [15:0] network_id;
    logic [15:0] stream_id;
    logic [15:0] service_id;
  } rec_t;

  function automatic logic [KEY_W-1:0] key_of(input rec_t r, input logic [2:0] sel);
    logic [KEY_W-1:0] k;
    unique case (sel)
      KEY_SPACE:   k = {9'd0, r.space};
      KEY_CHANNEL: k = r.channel;
      KEY_REMOTE:  k = {8'd0, r.remote_key};
      KEY_NETWORK: k = r.network_id;
      KEY_STREAM:  k = r.stream_id;
      default:     k = r.service_id;
    endcase
    return k;
  endfunction

endpackage

### hdl/rms_rec_mem.sv
// Record store: one write port and two registered read ports.
// Depends on rms_pkg for the record type.
`timescale 1ns / 1ps
module rms_rec_mem #(
  parameter int DEPTH = rms_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic [AW-1:0]  waddr,
  input  rms_pkg::rec_t  wdata,
  input  logic [AW-1:0]  raddr_a,
  input  logic [AW-1:0]  raddr_b,
  output rms_pkg::rec_t  rdata_a,
  output rms_pkg::rec_t  rdata_b
);

  rms_pkg::rec_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/rms_idx_mem.sv
// Position list store (sorted order or merge scratch), one write and two reads.
// Depends on rms_pkg only for its default depth.
`timescale 1ns / 1ps
module rms_idx_mem #(
  parameter int DEPTH = rms_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [AW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [AW-1:0] rdata_a,
  output logic [AW-1:0] rdata_b
);

  logic [AW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hdl/rms_ctrl.sv
// Load, merge sort and emission sequencer of the record merge sorter.
// Depends on rms_pkg, rms_rec_mem and rms_idx_mem.
`timescale 1ns / 1ps
module rms_ctrl #(
  parameter int DEPTH = rms_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [2:0]                  sort_key,
  input  logic                        descending,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  rms_pkg::rec_t               in_rec,
  input  logic                        in_last,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rms_pkg::rec_t               out_rec,
  output logic [rms_pkg::POS_W-1:0]   out_pos,
  output logic                        out_dropped,
  output logic                        out_last
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SD  = AW + 2;
  localparam int STW = $clog2(SD);
  localparam int SPW = $clog2(SD + 1);

  typedef enum logic [3:0] {
    S_LOAD, S_SPLIT, S_COPY_RD, S_COPY_WR, S_MRG_RD, S_MRG_KEY, S_MRG_CMP,
    S_EMIT_RD, S_EMIT_REC, S_EMIT_CAP, S_EMIT_OUT
  } state_t;

  state_t         state_r;
  logic [CW-1:0]  cnt_r, n_r;
  logic           ovf_r;
  logic [SPW-1:0] sp_r;
  logic [AW-1:0]  stk_first_r [SD];
  logic [AW-1:0]  stk_last_r  [SD];
  logic [1:0]     stk_ph_r    [SD];
  logic [AW-1:0]  f_r, l_r, m_r, idx_r, i_r, j_r, k_r, a_r, b_r;

  // Memory ports.
  logic          rec_we;
  logic [AW-1:0] rec_ra, rec_rb;
  rms_pkg::rec_t rec_da, rec_db;
  logic          ol_we;
  logic [AW-1:0] ol_wa, ol_wd, ol_ra, ol_da, ol_db;
  logic          sc_we;
  logic [AW-1:0] sc_ra, sc_rb, sc_da, sc_db;

  logic [STW-1:0] top_idx, push_idx;
  logic [AW-1:0]  t_first, t_last, t_mid;
  logic [CW-1:0]  cnt_inc;
  logic           has_room, take_left;
  logic [rms_pkg::KEY_W-1:0] ka, kb;

  assign in_ready = (state_r == S_LOAD);
  assign has_room = (cnt_r < CW'(DEPTH));
  assign cnt_inc  = has_room ? cnt_r + CW'(1) : cnt_r;
  assign top_idx  = STW'(sp_r - SPW'(1));
  assign push_idx = STW'(sp_r);
  assign t_first  = stk_first_r[top_idx];
  assign t_last   = stk_last_r[top_idx];
  assign t_mid    = AW'(({1'b0, t_first} + {1'b0, t_last}) >> 1);
  assign ka       = rms_pkg::key_of(rec_da, sort_key);
  assign kb       = rms_pkg::key_of(rec_db, sort_key);
  assign take_left = descending ? (ka >= kb) : (ka <= kb);

  always_comb begin
    rec_we = 1'b0;
    ol_we  = 1'b0;
    ol_wa  = k_r;
    ol_wd  = a_r;
    sc_we  = 1'b0;
    ol_ra  = n_r[AW-1:0];
    sc_ra  = i_r;
    sc_rb  = j_r;
    rec_ra = sc_da;
    rec_rb = sc_db;
    unique case (state_r)
      S_LOAD: begin
        rec_we = in_valid && has_room;
        ol_we  = in_valid && has_room;
        ol_wa  = cnt_r[AW-1:0];
        ol_wd  = cnt_r[AW-1:0];
      end
      S_COPY_RD: begin
        // The second half goes into scratch back to front.
        ol_ra = (idx_r <= m_r) ? idx_r
              : AW'({1'b0, l_r} + {1'b0, m_r} + (AW+1)'(1) - {1'b0, idx_r});
      end
      S_COPY_WR: sc_we = 1'b1;
      S_MRG_CMP: begin
        ol_we = 1'b1;
        ol_wd = take_left ? a_r : b_r;
      end
      S_EMIT_REC: rec_ra = ol_da;
      default: ;
    endcase
  end

  rms_rec_mem #(.DEPTH(DEPTH), .AW(AW)) u_rec (
    .clk(clk), .we(rec_we), .waddr(cnt_r[AW-1:0]), .wdata(in_rec),
    .raddr_a(rec_ra), .raddr_b(rec_rb), .rdata_a(rec_da), .rdata_b(rec_db)
  );

  rms_idx_mem #(.DEPTH(DEPTH), .AW(AW)) u_order (
    .clk(clk), .we(ol_we), .waddr(ol_wa), .wdata(ol_wd),
    .raddr_a(ol_ra), .raddr_b(ol_ra), .rdata_a(ol_da), .rdata_b(ol_db)
  );

  rms_idx_mem #(.DEPTH(DEPTH), .AW(AW)) u_scratch (
    .clk(clk), .we(sc_we), .waddr(idx_r), .wdata(ol_da),
    .raddr_a(sc_ra), .raddr_b(sc_rb), .rdata_a(sc_da), .rdata_b(sc_db)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      sp_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            cnt_r <= cnt_inc;
            if (!has_room) begin
              ovf_r <= 1'b1;
            end
            if (in_last) begin
              n_r <= '0;
              if (cnt_inc > CW'(1) && sort_key <= rms_pkg::KEY_SERVICE) begin
                stk_first_r[0] <= '0;
                stk_last_r[0]  <= AW'(cnt_inc - CW'(1));
                stk_ph_r[0]    <= 2'd0;
                sp_r           <= SPW'(1);
                state_r        <= S_SPLIT;
              end else begin
                state_r <= S_EMIT_RD;
              end
            end
          end
        end
        S_SPLIT: begin
          if (sp_r == '0) begin
            state_r <= S_EMIT_RD;
          end else if (t_first >= t_last) begin
            sp_r <= sp_r - SPW'(1);
          end else begin
            unique case (stk_ph_r[top_idx])
              2'd0: begin
                stk_ph_r[top_idx]    <= 2'd1;
                stk_first_r[push_idx] <= t_first;
                stk_last_r[push_idx]  <= t_mid;
                stk_ph_r[push_idx]    <= 2'd0;
                sp_r                  <= sp_r + SPW'(1);
              end
              2'd1: begin
                stk_ph_r[top_idx]    <= 2'd2;
                stk_first_r[push_idx] <= t_mid + AW'(1);
                stk_last_r[push_idx]  <= t_last;
                stk_ph_r[push_idx]    <= 2'd0;
                sp_r                  <= sp_r + SPW'(1);
              end
              default: begin
                f_r     <= t_first;
                l_r     <= t_last;
                m_r     <= t_mid;
                idx_r   <= t_first;
                sp_r    <= sp_r - SPW'(1);
                state_r <= S_COPY_RD;
              end
            endcase
          end
        end
        S_COPY_RD: state_r <= S_COPY_WR;
        S_COPY_WR: begin
          if (idx_r == l_r) begin
            i_r     <= f_r;
            j_r     <= l_r;
            k_r     <= f_r;
            state_r <= S_MRG_RD;
          end else begin
            idx_r   <= idx_r + AW'(1);
            state_r <= S_COPY_RD;
          end
        end
        S_MRG_RD: state_r <= S_MRG_KEY;
        S_MRG_KEY: begin
          a_r     <= sc_da;
          b_r     <= sc_db;
          state_r <= S_MRG_CMP;
        end
        S_MRG_CMP: begin
          if (take_left) begin
            i_r <= i_r + AW'(1);
          end else begin
            j_r <= j_r - AW'(1);
          end
          if (k_r == l_r) begin
            state_r <= S_SPLIT;
          end else begin
            k_r     <= k_r + AW'(1);
            state_r <= S_MRG_RD;
          end
        end
        S_EMIT_RD: state_r <= S_EMIT_REC;
        S_EMIT_REC: begin
          // Both order ports read the same entry here.
          out_pos <= rms_pkg::POS_W'(ol_db);
          state_r <= S_EMIT_CAP;
        end
        S_EMIT_CAP: begin
          out_rec     <= rec_da;
          out_dropped <= ovf_r;
          out_last    <= (n_r == cnt_r - CW'(1));
          out_valid   <= 1'b1;
          state_r     <= S_EMIT_OUT;
        end
        S_EMIT_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              cnt_r   <= '0;
              ovf_r   <= 1'b0;
              state_r <= S_LOAD;
            end else begin
              n_r     <= n_r + CW'(1);
              state_r <= S_EMIT_RD;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

### hdl/record_merge_sorter.sv
// Loading: a record is taken whenever in_valid and in_ready are high. Sorting (n records):
// top-down merge sort over ceil(log2 n) merge levels, with a split stack of ranges; each
// merge copies its range into scratch, then merges one entry at a time over the scratch
// and record memories. Emission: read, fetch, capture, output states; stalls on out_ready.
// Reset (synchronous, active low) empties the set and clears the configuration;
// memory contents are not cleared and no clearing pass is needed.
`timescale 1ns / 1ps
`include "record_merge_sorter_defines.svh"
module record_merge_sorter #(
  parameter int DEPTH = rms_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [6:0]  in_space,
  input  logic [15:0] in_channel,
  input  logic [7:0]  in_remote_key,
  input  logic [15:0] in_network_id,
  input  logic [15:0] in_stream_id,
  input  logic [15:0] in_service_id,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  out_load_position,
  output logic [6:0]  out_space,
  output logic [15:0] out_channel,
  output logic [7:0]  out_remote_key,
  output logic [15:0] out_network_id,
  output logic [15:0] out_stream_id,
  output logic [15:0] out_service_id,
  output logic        out_dropped,
  output logic        out_last_out
);

  logic [2:0]    sort_key_r;
  logic          descending_r;
  rms_pkg::rec_t in_rec, out_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sort_key_r   <= '0;
      descending_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == rms_pkg::REG_SORT_KEY) begin
        sort_key_r <= cfg_wdata;
      end else if (cfg_index == rms_pkg::REG_DESCENDING) begin
        descending_r <= cfg_wdata[0];
      end
    end
  end

  assign in_rec = '{space: in_space, channel: in_channel, remote_key: in_remote_key,
                    network_id: in_network_id, stream_id: in_stream_id,
                    service_id: in_service_id};

  rms_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk(clk), .rst_n(rst_n), .sort_key(sort_key_r), .descending(descending_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_rec(in_rec), .in_last(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_rec(out_rec),
    .out_pos(out_load_position), .out_dropped(out_dropped), .out_last(out_last_out)
  );

  assign out_space      = out_rec.space;
  assign out_channel    = out_rec.channel;
  assign out_remote_key = out_rec.remote_key;
  assign out_network_id = out_rec.network_id;
  assign out_stream_id  = out_rec.stream_id;
  assign out_service_id = out_rec.service_id;

  // Loading and emission never overlap.
  `RMS_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)
  // A closing record stops loading until the burst is out.
  `RMS_ASSERT_NEXT(a_close_stops_load, in_valid && in_ready && in_last_in, !in_ready)
  // Taking the final record of a burst reopens the block for a new set.
  `RMS_ASSERT_NEXT(a_reopen, out_valid && out_ready && out_last_out, in_ready && !out_valid)

endmodule
